// File: rtl/lbr_pkg.sv
package lbr_pkg;

  localparam int DEF_MAX_COLS  = 128;
  localparam int DEF_MAX_ROWS  = 128;
  localparam int DEF_FRAC_BITS = 8;
  localparam int DEF_TABLE_SIZE = 128;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_DATA_W  = 8;
  localparam int VAL_W       = 32;
  localparam int QUERY_W     = 16;
  localparam int ENTRY_W     = 2 * VAL_W + 1;

  typedef enum logic {
    FUNC_WRITE,
    FUNC_QUERY
  } func_t;

  typedef enum logic [0:0] {
    REG_TABLE_WIDTH,
    REG_TABLE_HEIGHT
  } cfg_reg_t;

  // size register held as its highest legal integer index (size - 2)
  function automatic int size_limit(input int v, input int hi);
    int c;
    begin
      c = v;
      if (c < 2) c = 2;
      if (c > hi) c = hi;
      return c - 2;
    end
  endfunction

endpackage

// File: rtl/lut_bilinear_remap.sv
// Bilinear lookup into a 2-D calibration table of (x,y) Q16.16 pairs.
//
// Slave stream: tuser carries func (0 writes one table entry, 1 queries a
// fractional position); tdata carries the entry address, valid mark, values
// and the query coordinates. A write gives no result beat. A query gives one
// master beat: tuser = ok, tdata = interpolated x and y (zero when not ok).
//
// The table sits in four single-port-read banks split by row and column
// parity, so the four neighbors of any query are read in the same cycle.
// One item is accepted per clock unless a receiver stall has filled the
// pipeline. A query passes through bank read, multiply, partial sum, and final
// sum with rounding into the output register, which drives the master side.
//
// Reset clears the pipeline and sets both size registers to 128; the table
// contents are undefined until written. When the receiver stalls, the output
// register and the three stages in front of it fill, and tready falls once
// all four hold a query. The user must write the size registers through the cfg
// port only while the block is idle; the block itself leaves this unchecked.
module lut_bilinear_remap
  import lbr_pkg::*;
#(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // entry_col, entry_row, entry_valid, entry_val_x, entry_val_y, query_x, query_y
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // result_x, result_y
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // ok
  output logic                   m_axis_tuser,
  input  logic                   cfg_we,
  input  cfg_reg_t               cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int S_W  = FRAC_BITS + 1;
  localparam int WW   = 2 * FRAC_BITS + 1;
  localparam int PW   = VAL_W + WW + 1;
  localparam int SW   = PW + 2;
  localparam int COLS_HALF = (MAX_COLS + 1) / 2;
  localparam int ROWS_HALF = (MAX_ROWS + 1) / 2;
  localparam int CH_W = (COLS_HALF > 1) ? $clog2(COLS_HALF) : 1;
  localparam int RH_W = (ROWS_HALF > 1) ? $clog2(ROWS_HALF) : 1;
  localparam int AW   = CH_W + RH_W;
  localparam int DEPTH = 1 << AW;
  localparam int LWC  = $clog2(MAX_COLS);
  localparam int LWR  = $clog2(MAX_ROWS);
  localparam int RST_LIM_W = size_limit(DEF_TABLE_SIZE, MAX_COLS);
  localparam int RST_LIM_H = size_limit(DEF_TABLE_SIZE, MAX_ROWS);
  localparam logic [S_W-1:0] SCALE = S_W'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] ROUND = SW'(1) << (2 * FRAC_BITS - 1);

  typedef struct packed {
    logic          in_bounds;
    logic          px;
    logic          py;
    logic [WW-1:0] w11;
    logic [WW-1:0] w12;
    logic [WW-1:0] w21;
    logic [WW-1:0] w22;
  } query_meta_t;

  // size limits
  logic [LWC-1:0] lim_w;
  logic [LWR-1:0] lim_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_w <= LWC'(RST_LIM_W);
      lim_h <= LWR'(RST_LIM_H);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TABLE_WIDTH:  lim_w <= LWC'(size_limit(int'(cfg_data), MAX_COLS));
        REG_TABLE_HEIGHT: lim_h <= LWR'(size_limit(int'(cfg_data), MAX_ROWS));
      endcase
    end
  end

  // handshake and stage enables
  logic v1, v2, v3;
  logic out_en, en3, en2, en1;
  logic s_acc, rd_en, wr_en;

  assign out_en = !m_axis_tvalid || m_axis_tready;
  assign en3 = !v3 || out_en;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // input beat fields
  logic [6:0]              wr_col;
  logic [6:0]              wr_row;
  logic [ENTRY_W-1:0]      wr_word;
  logic [QUERY_W-1:0]      qx;
  logic [QUERY_W-1:0]      qy;

  assign wr_col  = s_axis_tdata[6:0];
  assign wr_row  = s_axis_tdata[13:7];
  assign wr_word = {s_axis_tdata[14], s_axis_tdata[46:15], s_axis_tdata[78:47]};
  assign qx      = s_axis_tdata[94:79];
  assign qy      = s_axis_tdata[110:95];

  logic            wr_in_store;
  logic [1:0]      wr_bank;
  logic [AW-1:0]   wr_addr;

  assign wr_in_store = (32'(wr_col) < MAX_COLS) && (32'(wr_row) < MAX_ROWS);
  assign wr_bank = {wr_row[0], wr_col[0]};
  assign wr_addr = {RH_W'(wr_row[6:1]), CH_W'(wr_col[6:1])};
  assign wr_en = s_acc && (s_axis_tuser == FUNC_WRITE) && wr_in_store;
  assign rd_en = s_acc && (s_axis_tuser == FUNC_QUERY);

  // query address split and weights
  logic [QUERY_W-1:0]   ix, iy;
  logic [QUERY_W-1:0]   col_e, col_o, row_e, row_o;
  logic [S_W-1:0]       fx, fy, sx, sy;
  logic [AW-1:0]        raddr [4];
  query_meta_t          meta0;

  always_comb begin
    ix = qx >> FRAC_BITS;
    iy = qy >> FRAC_BITS;
    fx = S_W'(qx[FRAC_BITS-1:0]);
    fy = S_W'(qy[FRAC_BITS-1:0]);
    sx = SCALE - fx;
    sy = SCALE - fy;
    col_e = (ix >> 1) + QUERY_W'(ix[0]);
    col_o = ix >> 1;
    row_e = (iy >> 1) + QUERY_W'(iy[0]);
    row_o = iy >> 1;
    for (int b = 0; b < 4; b++) begin
      raddr[b] = {RH_W'(b[1] ? row_o : row_e), CH_W'(b[0] ? col_o : col_e)};
    end
    meta0.in_bounds = !qx[QUERY_W-1] && !qy[QUERY_W-1] &&
                      (ix <= QUERY_W'(lim_w)) && (iy <= QUERY_W'(lim_h));
    meta0.px  = ix[0];
    meta0.py  = iy[0];
    meta0.w11 = WW'(sx) * WW'(sy);
    meta0.w12 = WW'(fx) * WW'(sy);
    meta0.w21 = WW'(sx) * WW'(fy);
    meta0.w22 = WW'(fx) * WW'(fy);
  end

  // parity banks
  logic [ENTRY_W-1:0] bank_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 2'(b)) mem[wr_addr] <= wr_word;
      if (rd_en) rd_q <= mem[raddr[b]];
    end

    assign bank_q[b] = rd_q;
  end

  // stage 1: neighbor select and products
  query_meta_t          s1;
  logic [ENTRY_W-1:0]   p [4];
  logic [WW-1:0]        w [4];
  logic                 ok1;
  logic signed [PW-1:0] mx [4];
  logic signed [PW-1:0] my [4];

  always_comb begin
    p[0] = bank_q[{s1.py, s1.px}];
    p[1] = bank_q[{s1.py, !s1.px}];
    p[2] = bank_q[{!s1.py, s1.px}];
    p[3] = bank_q[{!s1.py, !s1.px}];
    w[0] = s1.w11;
    w[1] = s1.w12;
    w[2] = s1.w21;
    w[3] = s1.w22;
    ok1 = s1.in_bounds && p[0][ENTRY_W-1] && p[1][ENTRY_W-1] &&
          p[2][ENTRY_W-1] && p[3][ENTRY_W-1];
    for (int i = 0; i < 4; i++) begin
      mx[i] = PW'($signed(p[i][2*VAL_W-1:VAL_W])) * PW'($signed({1'b0, w[i]}));
      my[i] = PW'($signed(p[i][VAL_W-1:0])) * PW'($signed({1'b0, w[i]}));
    end
  end

  logic                 ok2;
  logic signed [PW-1:0] s2_x [4];
  logic signed [PW-1:0] s2_y [4];
  logic                 ok3;
  logic signed [SW-1:0] s3_ax, s3_bx, s3_ay, s3_by;
  logic signed [SW-1:0] acc_x, acc_y, sh_x, sh_y;

  assign acc_x = s3_ax + s3_bx + ROUND;
  assign acc_y = s3_ay + s3_by + ROUND;
  assign sh_x  = acc_x >>> (2 * FRAC_BITS);
  assign sh_y  = acc_y >>> (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= rd_en;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (out_en) m_axis_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) s1 <= meta0;
    if (en2 && v1) begin
      ok2 <= ok1;
      s2_x <= mx;
      s2_y <= my;
    end
    if (en3 && v2) begin
      ok3   <= ok2;
      s3_ax <= SW'(s2_x[0]) + SW'(s2_x[1]);
      s3_bx <= SW'(s2_x[2]) + SW'(s2_x[3]);
      s3_ay <= SW'(s2_y[0]) + SW'(s2_y[1]);
      s3_by <= SW'(s2_y[2]) + SW'(s2_y[3]);
    end
    if (out_en && v3) begin
      m_axis_tuser <= ok3;
      m_axis_tdata <= ok3 ? {sh_y[VAL_W-1:0], sh_x[VAL_W-1:0]} : '0;
    end
  end

  a_lim_range: assert property (@(posedge clk) disable iff (rst)
    (32'(lim_w) <= MAX_COLS - 2) && (32'(lim_h) <= MAX_ROWS - 2))
    else $error("size limit beyond table");

  a_empty_latency: assert property (@(posedge clk) disable iff (rst)
    (rd_en && !v1 && !v2 && !v3 && !m_axis_tvalid) |-> ##4 m_axis_tvalid)
    else $error("query lost in empty pipeline");

  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !out_en) |=> (v3 && $stable(s3_ax) && $stable(s3_ay)))
    else $error("stage 3 overwritten while stalled");

endmodule

// File: verif/lbr_remap_checker.sv
module lbr_remap_checker
  import lbr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tuser,
  input  logic                   cfg_we,
  input  cfg_reg_t               cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending,
  output int                     results_seen,
  output int                     ok_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = DEF_MAX_COLS;
  localparam int ROWS  = DEF_MAX_ROWS;
  localparam int FRAC  = DEF_FRAC_BITS;
  localparam int SCALE = 1 << FRAC;

  // slave tdata layout, msb first
  typedef struct packed {
    logic               pad;
    logic [QUERY_W-1:0] qy;
    logic [QUERY_W-1:0] qx;
    logic [VAL_W-1:0]   vy;
    logic [VAL_W-1:0]   vx;
    logic               valid;
    logic [6:0]         row;
    logic [6:0]         col;
  } remap_beat_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] rx;
    logic [VAL_W-1:0] ry;
  } remap_result_t;

  bit               grid_valid [COLS*ROWS];
  bit [VAL_W-1:0]   grid_x     [COLS*ROWS];
  bit [VAL_W-1:0]   grid_y     [COLS*ROWS];
  logic [7:0]       width_reg;
  logic [7:0]       height_reg;
  remap_result_t    answer_q[$];
  int               fail_count;
  int               beats_out;
  int               ok_count;

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    ok_seen = 0;
    fail_count = 0;
    beats_out = 0;
    ok_count = 0;
  end

  function automatic int dim_in_use(input logic [7:0] v, input int hi);
    int n;
    n = v;
    if (n < 2) n = 2;
    if (n > hi) n = hi;
    return n;
  endfunction

  // exact weighted sum, then divide by SCALE^2 rounding half up
  function automatic logic [VAL_W-1:0] blend_q16(input bit [VAL_W-1:0] p11, input bit [VAL_W-1:0] p12,
                                                 input bit [VAL_W-1:0] p21, input bit [VAL_W-1:0] p22,
                                                 input int fx, input int fy);
    longint acc;
    acc = longint'($signed(p11)) * ((SCALE - fx) * (SCALE - fy))
        + longint'($signed(p12)) * (fx * (SCALE - fy))
        + longint'($signed(p21)) * ((SCALE - fx) * fy)
        + longint'($signed(p22)) * (fx * fy);
    acc = acc + (longint'(1) << (2 * FRAC - 1));
    return VAL_W'(acc >>> (2 * FRAC));
  endfunction

  function automatic remap_result_t lookup(input logic [QUERY_W-1:0] qx,
                                           input logic [QUERY_W-1:0] qy);
    remap_result_t r;
    int ix, iy, fx, fy, a;
    r = '0;
    if (qx[QUERY_W-1] || qy[QUERY_W-1]) return r;
    ix = int'(qx[QUERY_W-2:FRAC]);
    iy = int'(qy[QUERY_W-2:FRAC]);
    if (ix > dim_in_use(width_reg, COLS) - 2 || iy > dim_in_use(height_reg, ROWS) - 2) return r;
    a = iy * COLS + ix;
    if (!(grid_valid[a] && grid_valid[a+1] && grid_valid[a+COLS] && grid_valid[a+COLS+1]))
      return r;
    fx = int'(qx[FRAC-1:0]);
    fy = int'(qy[FRAC-1:0]);
    r.ok = 1'b1;
    r.rx = blend_q16(grid_x[a], grid_x[a+1], grid_x[a+COLS], grid_x[a+COLS+1], fx, fy);
    r.ry = blend_q16(grid_y[a], grid_y[a+1], grid_y[a+COLS], grid_y[a+COLS+1], fx, fy);
    return r;
  endfunction

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    remap_beat_t   beat;
    remap_result_t want;
    int            a;
    if (rst) begin
      width_reg = 8'(DEF_TABLE_SIZE);
      height_reg = 8'(DEF_TABLE_SIZE);
      answer_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TABLE_WIDTH: width_reg = cfg_data;
          REG_TABLE_HEIGHT: height_reg = cfg_data;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat = s_axis_tdata;
        if (func_t'(s_axis_tuser) == FUNC_WRITE) begin
          a = int'(beat.row) * COLS + int'(beat.col);
          grid_valid[a] = beat.valid;
          grid_x[a] = beat.vx;
          grid_y[a] = beat.vy;
        end else begin
          answer_q.push_back(lookup(beat.qx, beat.qy));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (m_axis_tuser === 1'b1) ok_count++;
        if (answer_q.size() == 0) begin
          flag($sformatf("result beat with nothing outstanding: tuser=%b tdata=%h",
                         m_axis_tuser, m_axis_tdata));
        end else begin
          want = answer_q.pop_front();
          if (m_axis_tuser !== want.ok)
            flag($sformatf("result %0d ok: expected %b got %b", beats_out, want.ok, m_axis_tuser));
          if (m_axis_tdata[VAL_W-1:0] !== want.rx)
            flag($sformatf("result %0d result_x: expected %h got %h", beats_out, want.rx,
                           m_axis_tdata[VAL_W-1:0]));
          if (m_axis_tdata[2*VAL_W-1:VAL_W] !== want.ry)
            flag($sformatf("result %0d result_y: expected %h got %h", beats_out, want.ry,
                           m_axis_tdata[2*VAL_W-1:VAL_W]));
        end
      end
    end
    pending <= answer_q.size();
    errors <= fail_count;
    results_seen <= beats_out;
    ok_seen <= ok_count;
  end

endmodule

// File: verif/lut_bilinear_remap_tb.sv
module lut_bilinear_remap_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbr_pkg::*;

  localparam int COLS     = DEF_MAX_COLS;
  localparam int ROWS     = DEF_MAX_ROWS;
  localparam int IDLE_GAP = 12;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we = 1'b0;
  cfg_reg_t               cfg_index = REG_TABLE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int errors, pending, results_seen, ok_seen;

  bit written [COLS*ROWS];
  int eff_w = DEF_TABLE_SIZE;
  int eff_h = DEF_TABLE_SIZE;
  int burst_left = 0;
  int n_writes = 0;
  int n_queries = 0;
  int n_settings = 0;

  lut_bilinear_remap u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lbr_remap_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .results_seen  (results_seen),
    .ok_seen       (ok_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver stall patterns
  initial begin
    int mode, span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (int c = 0; c < span; c++) begin
        @(posedge clk);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((c % 24) >= 16);
        endcase
      end
    end
  end

  // sender in bursts; valid stays high across a burst
  task automatic push_item(input func_t f, input logic [IN_TDATA_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    s_axis_tdata <= d;
    s_axis_tuser <= f;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_entry(input int col, input int row, input bit ok,
                             input logic [VAL_W-1:0] vx, input logic [VAL_W-1:0] vy);
    push_item(FUNC_WRITE, {1'b0, 16'($urandom), 16'($urandom), vy, vx, ok, 7'(row), 7'(col)});
    written[row * COLS + col] = 1'b1;
    n_writes++;
  endtask

  task automatic query_at(input logic [QUERY_W-1:0] qx, input logic [QUERY_W-1:0] qy);
    push_item(FUNC_QUERY, {1'b0, qy, qx, 32'($urandom), 32'($urandom), 1'($urandom),
                           7'($urandom), 7'($urandom)});
    n_queries++;
  endtask

  // an in-bounds position whose cell is not fully written is pushed past the right edge
  task automatic safe_query(input int ix, input int iy, input int fx, input int fy);
    int a;
    a = iy * COLS + ix;
    if (ix <= eff_w - 2 && iy <= eff_h - 2 &&
        !(written[a] && written[a+1] && written[a+COLS] && written[a+COLS+1]))
      ix = $urandom_range(eff_w - 1, COLS - 1);
    query_at({1'b0, 7'(ix), 8'(fx)}, {1'b0, 7'(iy), 8'(fy)});
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic set_size(input int w, input int h);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_TABLE_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= REG_TABLE_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_w = (w < 2) ? 2 : (w > COLS) ? COLS : w;
    eff_h = (h < 2) ? 2 : (h > ROWS) ? ROWS : h;
    n_settings++;
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 19))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hffffffff;
      default: return 32'($urandom);
    endcase
  endfunction

  // biased toward both ends of 0..lim
  function automatic int pick_index(input int lim);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return lim;
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  function automatic int pick_frac();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      2: return 128;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic run_random(input int count);
    int sent, ix, iy, nq;
    logic [QUERY_W-1:0] qx, qy;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 75) begin
        // write a 2x2 cell with random content, some entries skipped, then query it
        ix = pick_index(eff_w - 2);
        iy = pick_index(eff_h - 2);
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 9) != 0) begin
            write_entry(ix + k % 2, iy + k / 2, $urandom_range(0, 9) != 0, rand_val(), rand_val());
            sent++;
          end
        end
        nq = $urandom_range(1, 5);
        for (int k = 0; k < nq; k++) begin
          safe_query(ix, iy, pick_frac(), pick_frac());
          sent++;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: write_entry($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                         1'($urandom), rand_val(), rand_val());
          1: begin
            qx = 16'($urandom);
            qy = 16'($urandom);
            if ($urandom_range(0, 1)) qx[QUERY_W-1] = 1'b1;
            else qy[QUERY_W-1] = 1'b1;
            query_at(qx, qy);
          end
          2: safe_query($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                        pick_frac(), pick_frac());
          default: query_at({1'b0, 7'($urandom_range(eff_w - 1, COLS - 1)), 8'($urandom)},
                            {1'b0, 15'($urandom)});
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes around the origin cell at reset sizes
    write_entry(0, 0, 1'b1, 32'h7fffffff, 32'h80000000);
    write_entry(1, 0, 1'b1, 32'h80000000, 32'h7fffffff);
    write_entry(0, 1, 1'b1, 32'h7fffffff, 32'h7fffffff);
    write_entry(1, 1, 1'b1, 32'h80000000, 32'h80000000);
    query_at(16'h0000, 16'h0000);
    query_at(16'h00ff, 16'h00ff);
    query_at(16'h0080, 16'h0080);
    query_at(16'h00ff, 16'h0000);
    query_at(16'h8000, 16'h0000);
    query_at(16'h0000, 16'hffff);
    // far corner, right and bottom edges
    for (int k = 0; k < 4; k++) write_entry(126 + k % 2, 126 + k / 2, 1'b1, rand_val(), rand_val());
    query_at({1'b0, 7'd126, 8'hff}, {1'b0, 7'd126, 8'h01});
    query_at({1'b0, 7'd127, 8'h00}, 16'h0000);
    query_at(16'h0000, {1'b0, 7'd127, 8'h00});
    query_at(16'h7fff, 16'h7fff);
    // invalid neighbor, then negative values
    write_entry(1, 1, 1'b0, 32'h00000000, 32'h00000000);
    query_at(16'h0040, 16'h0040);
    write_entry(1, 1, 1'b1, 32'hffffffff, 32'h00000001);
    query_at(16'h0080, 16'h0080);

    run_random(70);
    set_size(2, 2);
    run_random(60);
    set_size(0, 1);
    run_random(50);
    set_size(255, 129);
    run_random(70);
    set_size(128, 2);
    run_random(70);
    set_size(2, 128);
    run_random(70);
    set_size($urandom_range(3, 127), $urandom_range(3, 127));
    run_random(80);
    set_size(128, 128);
    run_random(80);
    wait_idle();

    $display("run: %0d beats in (%0d entry writes, %0d lookups) over %0d size settings",
             n_writes + n_queries, n_writes, n_queries, n_settings + 1);
    $display("run: %0d results checked, %0d of them interpolated", results_seen, ok_seen);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lbr_pkg.sv
rtl/lut_bilinear_remap.sv
verif/lbr_remap_checker.sv
verif/lut_bilinear_remap_tb.sv
